// ===== rtl/lbsr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbsr_pkg
// Shared types, widths, codes and helpers of the log buffer space reserver.
// ----------------------------------------------------------------------------
package lbsr_pkg;

  localparam int OFF_W           = 21;
  localparam int CNT_W           = 17;
  localparam int ACT_W           = 2;
  localparam int ST_W            = 3;
  localparam int SHIFT_W         = 3;
  localparam int ENTRY_HDR_BYTES = 16;
  localparam int NEED_W          = OFF_W + 1;
  localparam int SUM_W           = OFF_W + 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = OFF_W;

  localparam logic [ACT_W-1:0] ACT_CHECKOUT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MARK_FULL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CHECKIN   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_REOPEN    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_RETRY_FULL  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL_ACTIVE = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL_IDLE   = 3'd3;
  localparam logic [ST_W-1:0] ST_TOO_SMALL   = 3'd4;
  localparam logic [ST_W-1:0] ST_ALL_DONE    = 3'd5;
  localparam logic [ST_W-1:0] ST_UNDERFLOW   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_SHIFT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_MODE    = 2'd3;

  localparam logic [OFF_W-1:0]   RST_BUFFER_BYTES = OFF_W'(9216);
  localparam logic [OFF_W-1:0]   RST_HEADER_BYTES = OFF_W'(64);
  localparam logic [SHIFT_W-1:0] RST_ALIGN_SHIFT  = SHIFT_W'(3);

  typedef struct packed {
    logic [OFF_W-1:0]   buffer_bytes;
    logic [OFF_W-1:0]   header_bytes;
    logic [SHIFT_W-1:0] align_shift;
    logic               fast_mode;
  } cfg_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [OFF_W-1:0] entry_bytes;
  } req_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lbsr_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbsr interfaces
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface lbsr_req_if;
  logic                      valid;
  logic                      ready;
  logic [lbsr_pkg::ACT_W-1:0] action;
  logic [lbsr_pkg::OFF_W-1:0] entry_bytes;

  modport source (output valid, action, entry_bytes, input ready);
  modport sink   (input valid, action, entry_bytes, output ready);
endinterface

interface lbsr_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [lbsr_pkg::ST_W-1:0]  status;
  logic [lbsr_pkg::OFF_W-1:0] entry_offset;
  logic [lbsr_pkg::CNT_W-1:0] writers_now;
  logic [lbsr_pkg::CNT_W-1:0] entries_now;
  logic [lbsr_pkg::OFF_W-1:0] fill_now;
  logic                      is_full;

  modport source (output valid, status, entry_offset, writers_now, entries_now,
                  fill_now, is_full, input ready);
  modport sink   (input valid, status, entry_offset, writers_now, entries_now,
                  fill_now, is_full, output ready);
endinterface

interface lbsr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lbsr_pkg::CFG_IDX_W-1:0]  index;
  logic [lbsr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/lbsr_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbsr_cfg_regs
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
module lbsr_cfg_regs (
  input  wire logic     clk,
  input  wire logic     rst,
  lbsr_cfg_if.sink      cfg,
  output lbsr_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.buffer_bytes <= lbsr_pkg::RST_BUFFER_BYTES;
      regs.header_bytes <= lbsr_pkg::RST_HEADER_BYTES;
      regs.align_shift  <= lbsr_pkg::RST_ALIGN_SHIFT;
      regs.fast_mode    <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lbsr_pkg::REG_BUFFER_BYTES: regs.buffer_bytes <= cfg.data;
        lbsr_pkg::REG_HEADER_BYTES: regs.header_bytes <= cfg.data;
        lbsr_pkg::REG_ALIGN_SHIFT: regs.align_shift <= cfg.data[lbsr_pkg::SHIFT_W-1:0];
        lbsr_pkg::REG_FAST_MODE: regs.fast_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lbsr_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbsr_in_stage
// Request input register; refills in the cycle the engine takes its item.
// ----------------------------------------------------------------------------
module lbsr_in_stage (
  input  wire logic      clk,
  input  wire logic      rst,
  lbsr_req_if.sink       req,
  input  wire logic      take,
  output logic           item_valid,
  output lbsr_pkg::req_t item
);

  assign req.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.action      <= req.action;
      item.entry_bytes <= req.entry_bytes;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lbsr_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbsr_engine
// Buffer state, single-pass request evaluation and the result register.
// ----------------------------------------------------------------------------
module lbsr_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lbsr_pkg::cfg_t regs,
  input  wire logic           item_valid,
  input  wire lbsr_pkg::req_t item,
  output logic                take,
  lbsr_rsp_if.source          rsp
);

  localparam int OFF_W  = lbsr_pkg::OFF_W;
  localparam int CNT_W  = lbsr_pkg::CNT_W;
  localparam int NEED_W = lbsr_pkg::NEED_W;
  localparam int SUM_W  = lbsr_pkg::SUM_W;

  logic [OFF_W-1:0] used_bytes, used_bytes_next;
  logic [CNT_W-1:0] writer_count, writer_count_next;
  logic [CNT_W-1:0] entry_total, entry_total_next;
  logic             full_flag, full_flag_next;

  logic [lbsr_pkg::ST_W-1:0] status_next;
  logic [OFF_W-1:0]          offset_next;

  logic [NEED_W-1:0] amask;
  logic [NEED_W-1:0] need;
  logic [SUM_W-1:0]  sum;
  logic              fits;
  logic [OFF_W-1:0]  payload_off;
  logic              out_valid;

  assign take          = item_valid && (!out_valid || rsp.ready);
  assign rsp.valid     = out_valid;

  assign amask       = (NEED_W'(1) << regs.align_shift) - NEED_W'(1);
  assign need        = (NEED_W'(item.entry_bytes) + NEED_W'(lbsr_pkg::ENTRY_HDR_BYTES)
                        + amask) & ~amask;
  assign sum         = SUM_W'(used_bytes) + SUM_W'(need);
  assign fits        = sum <= SUM_W'(regs.buffer_bytes);
  assign payload_off = used_bytes + OFF_W'(lbsr_pkg::ENTRY_HDR_BYTES);

  always_comb begin
    used_bytes_next   = used_bytes;
    writer_count_next = writer_count;
    entry_total_next  = entry_total;
    full_flag_next    = full_flag;
    status_next       = lbsr_pkg::ST_OK;
    offset_next       = '0;
    unique case (item.action)
      lbsr_pkg::ACT_CHECKOUT: begin
        if (regs.fast_mode) begin
          if (fits) begin
            offset_next      = payload_off;
            used_bytes_next  = sum[OFF_W-1:0];
            entry_total_next = lbsr_pkg::sat_inc(entry_total);
          end else begin
            status_next = lbsr_pkg::ST_FULL_IDLE;
          end
        end else if (full_flag) begin
          status_next = lbsr_pkg::ST_RETRY_FULL;
        end else if (fits) begin
          offset_next       = payload_off;
          used_bytes_next   = sum[OFF_W-1:0];
          entry_total_next  = lbsr_pkg::sat_inc(entry_total);
          writer_count_next = lbsr_pkg::sat_inc(writer_count);
        end else if (entry_total == '0) begin
          status_next = lbsr_pkg::ST_TOO_SMALL;
        end else begin
          full_flag_next = 1'b1;
          status_next    = (writer_count != '0) ? lbsr_pkg::ST_FULL_ACTIVE
                                                : lbsr_pkg::ST_FULL_IDLE;
        end
      end
      lbsr_pkg::ACT_MARK_FULL: begin
        if (!regs.fast_mode) begin
          if (full_flag) begin
            status_next = lbsr_pkg::ST_RETRY_FULL;
          end else if (entry_total != '0) begin
            full_flag_next = 1'b1;
            status_next    = (writer_count != '0) ? lbsr_pkg::ST_FULL_ACTIVE
                                                  : lbsr_pkg::ST_FULL_IDLE;
          end
        end
      end
      lbsr_pkg::ACT_CHECKIN: begin
        if (!regs.fast_mode) begin
          if (writer_count == '0) begin
            status_next = lbsr_pkg::ST_UNDERFLOW;
          end else begin
            writer_count_next = writer_count - CNT_W'(1);
            if (writer_count == CNT_W'(1) && full_flag) begin
              status_next = lbsr_pkg::ST_ALL_DONE;
            end
          end
        end
      end
      lbsr_pkg::ACT_REOPEN: begin
        used_bytes_next   = regs.header_bytes;
        writer_count_next = '0;
        entry_total_next  = '0;
        full_flag_next    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_bytes   <= '0;
      writer_count <= '0;
      entry_total  <= '0;
      full_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        used_bytes   <= used_bytes_next;
        writer_count <= writer_count_next;
        entry_total  <= entry_total_next;
        full_flag    <= full_flag_next;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.status       <= status_next;
      rsp.entry_offset <= offset_next;
      rsp.writers_now  <= writer_count_next;
      rsp.entries_now  <= entry_total_next;
      rsp.fill_now     <= used_bytes_next;
      rsp.is_full      <= full_flag_next;
    end
  end

  a_retry_is_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.status == lbsr_pkg::ST_RETRY_FULL |-> rsp.is_full)
    else $error("retry reported on a buffer that is not full");

  a_full_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.status == lbsr_pkg::ST_FULL_ACTIVE
      |-> rsp.is_full && rsp.writers_now != '0)
    else $error("full with active writers but state disagrees");

  a_all_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.status == lbsr_pkg::ST_ALL_DONE
      |-> rsp.is_full && rsp.writers_now == '0)
    else $error("last writer done reported with writers left");

  a_offset_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.entry_offset != '0 |-> rsp.status == lbsr_pkg::ST_OK)
    else $error("entry offset returned on a failed request");

  a_state_held: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(used_bytes) && $stable(entry_total) && $stable(writer_count))
    else $error("buffer state changed without a transaction");

endmodule
`default_nettype wire

// ===== rtl/log_buffer_space_reserver_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// log_buffer_space_reserver_top
// Reserves log buffer space for writers: checkout, mark full, checkin, reopen.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one result transaction, in order.
// A request is registered, evaluated against the buffer state in one pass,
// and its result registered. One request is accepted per cycle while the
// result channel is ready, since the state update (one aligned add and one
// compare against the buffer size) is combinational; the input register
// lets a new request enter while a result waits. Config writes are taken
// at once and should be issued while no request is pending.
module log_buffer_space_reserver_top (
  input  wire logic clk,
  input  wire logic rst,
  lbsr_cfg_if.sink  cfg,
  lbsr_req_if.sink  req,
  lbsr_rsp_if.source rsp
);

  lbsr_pkg::cfg_t regs;
  lbsr_pkg::req_t item;
  logic           item_valid;
  logic           take;

  lbsr_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lbsr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  lbsr_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .rsp        (rsp)
  );

endmodule
`default_nettype wire
